### rtl/core/battery_gauge_monitor_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery gauge monitor
// ----------------------------------------------------------------------------
`ifndef BATTERY_GAUGE_MONITOR_TOP_ASSERT_SVH
`define BATTERY_GAUGE_MONITOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BGM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgm check failed");

// next-cycle implication
`define BGM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgm check failed");

`endif

### rtl/core/bgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgm_pkg
// Types, constants and table functions of the battery gauge monitor.
// ----------------------------------------------------------------------------
package bgm_pkg;

  localparam int DW = 30;   // serial unit word: 14b code x 16b scale
  localparam int CW = 5;    // serial step counter

  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_MEAS = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  localparam logic [1:0] CS_NORMAL   = 2'd0;
  localparam logic [1:0] CS_CHARGING = 2'd1;
  localparam logic [1:0] CS_COMPLETE = 2'd2;

  localparam logic       CFG_MULT = 1'b0;
  localparam logic       CFG_DIV  = 1'b1;

  localparam logic [15:0] FULL_MV    = 16'd4100;
  localparam logic [15:0] ALARM_MV   = 16'd3615;
  localparam logic [6:0]  CHG_LIMIT  = 7'd29;
  localparam logic [6:0]  DONE_LIMIT = 7'd9;
  localparam logic [6:0]  CNT_MAX    = 7'd100;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic [6:0]  NOTICE_HI  = 7'd40;
  localparam logic [6:0]  NOTICE_LO  = 7'd20;
  localparam logic [15:0] FILT_DEN   = 16'd10;
  localparam logic [15:0] MV_MAX     = 16'hFFFF;

  localparam logic [CW-1:0] LEN_MUL  = 5'd14;
  localparam logic [CW-1:0] LEN_MV   = 5'd30;
  localparam logic [CW-1:0] LEN_WIDE = 5'd20;
  localparam logic [CW-1:0] LEN_PCT  = 5'd8;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_AVG  = 9'b000001000,
    S_FILT = 9'b000010000,
    S_PCT  = 9'b000100000,
    S_PDIV = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic          start;
    logic          div;
    logic [CW-1:0] len;
  } unit_req_t;

  function automatic logic [15:0] volt_tab(input logic [2:0] i);
    logic [15:0] v;
    unique case (i)
      3'd0: v = 16'd4142;
      3'd1: v = 16'd3980;
      3'd2: v = 16'd3880;
      3'd3: v = 16'd3803;
      3'd4: v = 16'd3752;
      3'd5: v = 16'd3717;
      3'd6: v = 16'd3683;
      default: v = 16'd3610;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] pct_tab(input logic [2:0] i);
    logic [6:0] p;
    unique case (i)
      3'd0: p = 7'd100;
      3'd1: p = 7'd86;
      3'd2: p = 7'd72;
      3'd3: p = 7'd58;
      3'd4: p = 7'd43;
      3'd5: p = 7'd29;
      3'd6: p = 7'd15;
      default: p = 7'd1;
    endcase
    return p;
  endfunction

  // mV per percent inside the segment ending at point i
  function automatic logic [15:0] step_tab(input logic [2:0] i);
    logic [15:0] s;
    unique case (i)
      3'd1: s = 16'd11;
      3'd2: s = 16'd7;
      3'd3: s = 16'd5;
      3'd4: s = 16'd3;
      3'd5: s = 16'd2;
      3'd6: s = 16'd2;
      3'd7: s = 16'd5;
      default: s = 16'd1;
    endcase
    return s;
  endfunction

  // first point at or below v; bit 3 set when below all points
  function automatic logic [3:0] seg_find(input logic [15:0] v);
    logic [3:0] idx;
    idx = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if (v >= volt_tab(3'(k))) idx = 4'(k);
    end
    return idx;
  endfunction

  function automatic logic [2:0] level_of(input logic [6:0] p);
    logic [2:0] l;
    priority if (p >= 7'd80) l = 3'd4;
    else if (p >= 7'd60) l = 3'd3;
    else if (p >= 7'd40) l = 3'd2;
    else if (p >= 7'd20) l = 3'd1;
    else l = 3'd0;
    return l;
  endfunction

endpackage

### rtl/core/bgm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgm_in_if / bgm_out_if
// Valid/ready channels carrying measurement items and results.
// ----------------------------------------------------------------------------
interface bgm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [13:0] adc_average;
  logic        usb_connected;
  logic        charging_pin_low;
  logic        monitor_idle;

  modport source (output valid, op, adc_average, usb_connected, charging_pin_low,
                  monitor_idle, input ready);
  modport sink   (input valid, op, adc_average, usb_connected, charging_pin_low,
                  monitor_idle, output ready);
endinterface

interface bgm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] voltage_mv;
  logic [6:0]  percent;
  logic [2:0]  level;
  logic [1:0]  charger_state;
  logic        low_battery_alarm;
  logic        twenty_percent_notice;
  logic        charge_start_event;
  logic        charge_stop_event;

  modport source (output valid, voltage_mv, percent, level, charger_state,
                  low_battery_alarm, twenty_percent_notice, charge_start_event,
                  charge_stop_event, input ready);
  modport sink   (input valid, voltage_mv, percent, level, charger_state,
                  low_battery_alarm, twenty_percent_notice, charge_start_event,
                  charge_stop_event, output ready);
endinterface

### rtl/core/bgm_serial_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgm_serial_unit
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module bgm_serial_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bgm_pkg::unit_req_t           req,
  input  logic [bgm_pkg::DW-1:0]       opa,   // dividend left-aligned / multiplier
  input  logic [15:0]                  opb,
  output logic                         done,
  output logic [bgm_pkg::DW-1:0]       result
);

  logic                      busy_r, busy_nxt;
  logic                      div_r, div_nxt;
  logic                      done_r, done_nxt;
  logic [bgm_pkg::CW-1:0]    cnt_r, cnt_nxt;
  logic [bgm_pkg::DW-1:0]    acc_r, acc_nxt;
  logic [15:0]               rem_r, rem_nxt;
  logic [15:0]               b_r, b_nxt;
  logic [13:0]               src_r, src_nxt;
  logic [16:0]               trial;

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    src_nxt  = src_r;
    done_nxt = 1'b0;
    trial    = {rem_r, acc_r[bgm_pkg::DW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.div;
      cnt_nxt  = req.len;
      b_nxt    = opb;
      rem_nxt  = '0;
      src_nxt  = opa[13:0];
      acc_nxt  = req.div ? opa : '0;
    end else if (busy_r) begin
      if (div_r) begin
        if (trial >= {1'b0, b_r}) begin
          rem_nxt = 16'(trial - {1'b0, b_r});
          acc_nxt = {acc_r[bgm_pkg::DW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[15:0];
          acc_nxt = {acc_r[bgm_pkg::DW-2:0], 1'b0};
        end
      end else begin
        acc_nxt = {acc_r[bgm_pkg::DW-2:0], 1'b0}
                + (src_r[13] ? {{(bgm_pkg::DW-16){1'b0}}, b_r} : '0);
        src_nxt = {src_r[12:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
    src_r <= src_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### rtl/core/battery_gauge_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_gauge_monitor_top
// Battery voltage filter, percent gauge, alarms and charger tracking.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_ch   | in  | op, adc_average, usb_connected, charging_pin_low, monitor_idle
//  out_ch  | out | voltage_mv, percent, level, charger_state, alarm/notice/events
//  cfg_*   | in  | index 0 scale multiplier, 1 scale divisor
//
// Every multiply and divide runs through the one bit-serial unit, one bit per
// cycle, which sets the time an item takes. One item in flight; the next is
// taken while a result waits in the output register. Reset is synchronous;
// it sets the state machine, gauge and config registers but not the output
// payload or the per-item flags.
module battery_gauge_monitor_top #(
  parameter int SEED_SAMPLES = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  bgm_in_if.sink           in_ch,
  bgm_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data
);

  bgm_pkg::state_t          st_r, st_nxt;
  logic [15:0]              mult_r, divsr_r;
  logic [1:0]               op_r, op_nxt;
  logic [15:0]              fv_r, fv_nxt;
  logic [6:0]               pct_r, pct_nxt;
  logic [6:0]               fcc_r, fcc_nxt;
  logic                     nsent_r, nsent_nxt;
  logic                     chg_r, chg_nxt;
  logic [19:0]              sum_r, sum_nxt;
  logic [3:0]               scnt_r, scnt_nxt;
  logic [2:0]               seg_r, seg_nxt;
  logic [1:0]               cs_r, cs_nxt;
  logic                     alarm_r, alarm_nxt;
  logic                     notice_r, notice_nxt;
  logic                     evs_r, evs_nxt;
  logic                     eve_r, eve_nxt;

  logic                     ov_r, ov_nxt;
  logic [15:0]              o_mv_r;
  logic [6:0]               o_pct_r;
  logic [1:0]               o_cs_r;
  logic                     o_alarm_r, o_notice_r, o_evs_r, o_eve_r;
  logic                     load_out;

  bgm_pkg::unit_req_t       ureq;
  logic [bgm_pkg::DW-1:0]   u_a, u_res;
  logic [15:0]              u_b;
  logic                     u_done;

  logic [1:0]               cs_dec;
  logic                     complete_seed;
  logic                     eval;
  logic [15:0]              mv;
  logic [19:0]              filt_num;
  logic [3:0]               seg;
  logic [15:0]              vdiff;
  logic [4:0]               scnt_inc;

  bgm_serial_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ureq),
    .opa    (u_a),
    .opb    (u_b),
    .done   (u_done),
    .result (u_res)
  );

  assign in_ch.ready = rst_n && (st_r == bgm_pkg::S_IDLE);
  assign load_out    = (st_r == bgm_pkg::S_OUT) && (!ov_r || out_ch.ready);

  always_comb begin
    priority if (!in_ch.usb_connected) cs_dec = bgm_pkg::CS_NORMAL;
    else if (in_ch.charging_pin_low)
      cs_dec = (fcc_r > bgm_pkg::CHG_LIMIT) ? bgm_pkg::CS_NORMAL : bgm_pkg::CS_CHARGING;
    else
      cs_dec = (fcc_r > bgm_pkg::DONE_LIMIT) ? bgm_pkg::CS_COMPLETE : bgm_pkg::CS_CHARGING;
  end

  assign scnt_inc      = {1'b0, scnt_r} + 5'd1;
  assign complete_seed = (5'({1'b0, scnt_inc[3:0]}) >= 5'(SEED_SAMPLES));
  assign eval = ((in_ch.op == bgm_pkg::OP_SEED) && complete_seed)
             || ((in_ch.op == bgm_pkg::OP_MEAS) && in_ch.monitor_idle)
             || (in_ch.op == bgm_pkg::OP_POLL);
  assign mv = ((divsr_r == '0) || (u_res[bgm_pkg::DW-1:16] != '0))
              ? bgm_pkg::MV_MAX : u_res[15:0];
  assign filt_num = {3'b000, mv, 1'b0} + {1'b0, fv_r, 3'b000};
  assign seg   = bgm_pkg::seg_find(fv_r);
  assign vdiff = fv_r - bgm_pkg::volt_tab(seg[2:0]);

  always_comb begin
    st_nxt     = st_r;
    op_nxt     = op_r;
    fv_nxt     = fv_r;
    pct_nxt    = pct_r;
    fcc_nxt    = fcc_r;
    nsent_nxt  = nsent_r;
    chg_nxt    = chg_r;
    sum_nxt    = sum_r;
    scnt_nxt   = scnt_r;
    seg_nxt    = seg_r;
    cs_nxt     = cs_r;
    alarm_nxt  = alarm_r;
    notice_nxt = notice_r;
    evs_nxt    = evs_r;
    eve_nxt    = eve_r;
    ureq       = '0;
    u_a        = '0;
    u_b        = '0;
    unique case (st_r)
      bgm_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.op;
          cs_nxt     = cs_dec;
          alarm_nxt  = 1'b0;
          notice_nxt = 1'b0;
          evs_nxt    = 1'b0;
          eve_nxt    = 1'b0;
          if (eval && !in_ch.usb_connected) fcc_nxt = '0;
          if ((in_ch.op == bgm_pkg::OP_SEED)
              || ((in_ch.op == bgm_pkg::OP_MEAS) && in_ch.monitor_idle)) begin
            ureq.start = 1'b1;
            ureq.len   = bgm_pkg::LEN_MUL;
            u_a        = {16'b0, in_ch.adc_average};
            u_b        = mult_r;
            st_nxt     = bgm_pkg::S_MUL;
          end else begin
            if (in_ch.op == bgm_pkg::OP_POLL) begin
              if (cs_dec == bgm_pkg::CS_CHARGING) begin
                if (!chg_r) begin
                  chg_nxt = 1'b1;
                  evs_nxt = 1'b1;
                end
              end else if (chg_r) begin
                chg_nxt = 1'b0;
                eve_nxt = 1'b1;
              end
            end
            st_nxt = bgm_pkg::S_OUT;
          end
        end
      end
      bgm_pkg::S_MUL: begin
        if (u_done) begin
          ureq.start = 1'b1;
          ureq.div   = 1'b1;
          ureq.len   = bgm_pkg::LEN_MV;
          u_a        = u_res;
          u_b        = divsr_r;
          st_nxt     = bgm_pkg::S_DIV;
        end
      end
      bgm_pkg::S_DIV: begin
        if (u_done) begin
          if (op_r == bgm_pkg::OP_SEED) begin
            sum_nxt  = sum_r + {4'b0, mv};
            scnt_nxt = scnt_inc[3:0];
            if (5'({1'b0, scnt_inc[3:0]}) >= 5'(SEED_SAMPLES)) begin
              ureq.start = 1'b1;
              ureq.div   = 1'b1;
              ureq.len   = bgm_pkg::LEN_WIDE;
              u_a        = {sum_r + {4'b0, mv}, 10'b0};
              u_b        = 16'(SEED_SAMPLES);
              st_nxt     = bgm_pkg::S_AVG;
            end else begin
              st_nxt = bgm_pkg::S_OUT;
            end
          end else begin
            ureq.start = 1'b1;
            ureq.div   = 1'b1;
            ureq.len   = bgm_pkg::LEN_WIDE;
            u_a        = {filt_num, 10'b0};
            u_b        = bgm_pkg::FILT_DEN;
            st_nxt     = bgm_pkg::S_FILT;
          end
        end
      end
      bgm_pkg::S_AVG: begin
        if (u_done) begin
          fv_nxt   = u_res[15:0];
          sum_nxt  = '0;
          scnt_nxt = '0;
          chg_nxt  = 1'b0;
          st_nxt   = bgm_pkg::S_PCT;
        end
      end
      bgm_pkg::S_FILT: begin
        if (u_done) begin
          fv_nxt = u_res[15:0];
          st_nxt = bgm_pkg::S_PCT;
        end
      end
      bgm_pkg::S_PCT: begin
        seg_nxt = seg[2:0];
        priority if (cs_r == bgm_pkg::CS_COMPLETE || seg == 4'd0) begin
          pct_nxt = bgm_pkg::PCT_FULL;
          st_nxt  = bgm_pkg::S_FIN;
        end else if (seg[3]) begin
          pct_nxt = '0;
          st_nxt  = bgm_pkg::S_FIN;
        end else begin
          ureq.start = 1'b1;
          ureq.div   = 1'b1;
          ureq.len   = bgm_pkg::LEN_PCT;
          u_a        = {vdiff[7:0], 22'b0};
          u_b        = bgm_pkg::step_tab(seg[2:0]);
          st_nxt     = bgm_pkg::S_PDIV;
        end
      end
      bgm_pkg::S_PDIV: begin
        if (u_done) begin
          pct_nxt = u_res[6:0] + bgm_pkg::pct_tab(seg_r);
          st_nxt  = bgm_pkg::S_FIN;
        end
      end
      bgm_pkg::S_FIN: begin
        if (op_r == bgm_pkg::OP_MEAS) begin
          if (nsent_r && pct_r > bgm_pkg::NOTICE_HI) nsent_nxt = 1'b0;
          if ((!nsent_r || pct_r > bgm_pkg::NOTICE_HI) && pct_r <= bgm_pkg::NOTICE_LO) begin
            notice_nxt = 1'b1;
            nsent_nxt  = 1'b1;
          end
          alarm_nxt = !chg_r && (fv_r < bgm_pkg::ALARM_MV);
          if (fv_r >= bgm_pkg::FULL_MV) begin
            if (fcc_r < bgm_pkg::CNT_MAX) fcc_nxt = fcc_r + 7'd1;
          end else begin
            fcc_nxt = '0;
          end
        end
        st_nxt = bgm_pkg::S_OUT;
      end
      bgm_pkg::S_OUT: begin
        if (load_out) st_nxt = bgm_pkg::S_IDLE;
      end
      default: st_nxt = bgm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ch.ready) ov_nxt = 1'b0;
    if (load_out) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= bgm_pkg::S_IDLE;
      mult_r  <= 16'd1;
      divsr_r <= 16'd1;
      fv_r    <= '0;
      pct_r   <= '0;
      fcc_r   <= '0;
      nsent_r <= 1'b1;
      chg_r   <= 1'b0;
      sum_r   <= '0;
      scnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      fv_r    <= fv_nxt;
      pct_r   <= pct_nxt;
      fcc_r   <= fcc_nxt;
      nsent_r <= nsent_nxt;
      chg_r   <= chg_nxt;
      sum_r   <= sum_nxt;
      scnt_r  <= scnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bgm_pkg::CFG_MULT: mult_r  <= cfg_data;
          bgm_pkg::CFG_DIV:  divsr_r <= cfg_data;
          default: ;
        endcase
      end
    end
    op_r     <= op_nxt;
    seg_r    <= seg_nxt;
    cs_r     <= cs_nxt;
    alarm_r  <= alarm_nxt;
    notice_r <= notice_nxt;
    evs_r    <= evs_nxt;
    eve_r    <= eve_nxt;
    if (load_out) begin
      o_mv_r     <= fv_r;
      o_pct_r    <= pct_r;
      o_cs_r     <= cs_r;
      o_alarm_r  <= alarm_r;
      o_notice_r <= notice_r;
      o_evs_r    <= evs_r;
      o_eve_r    <= eve_r;
    end
  end

  assign out_ch.valid                 = ov_r;
  assign out_ch.voltage_mv            = o_mv_r;
  assign out_ch.percent               = o_pct_r;
  assign out_ch.level                 = bgm_pkg::level_of(o_pct_r);
  assign out_ch.charger_state         = o_cs_r;
  assign out_ch.low_battery_alarm     = o_alarm_r;
  assign out_ch.twenty_percent_notice = o_notice_r;
  assign out_ch.charge_start_event    = o_evs_r;
  assign out_ch.charge_stop_event     = o_eve_r;

endmodule

### rtl/core/bgm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgm_checker
// Port-level checks of the battery gauge monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_gauge_monitor_top_assert.svh"

module bgm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] voltage_mv,
  input logic [6:0]  percent,
  input logic [2:0]  level,
  input logic [1:0]  charger_state,
  input logic        charge_start_event,
  input logic        charge_stop_event
)
;

  `BGM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(voltage_mv))
  `BGM_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `BGM_ASSERT_NOW(a_pct_range, out_valid, percent <= 7'd100 && level <= 3'd4)
  `BGM_ASSERT_NOW(a_event_state, out_valid && charge_start_event,
                  !charge_stop_event && charger_state == 2'd1)

endmodule

bind battery_gauge_monitor_top bgm_checker u_bgm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .voltage_mv         (out_ch.voltage_mv),
  .percent            (out_ch.percent),
  .level              (out_ch.level),
  .charger_state      (out_ch.charger_state),
  .charge_start_event (out_ch.charge_start_event),
  .charge_stop_event  (out_ch.charge_stop_event)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery gauge monitor: a directed table, then
// random seed/measure/poll traffic over several scale settings and idle mixes,
// each result beat checked against a table entry or the in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int SEEDS = 10;

  typedef struct packed {
    logic [15:0] mv;
    logic [6:0]  pct;
    logic [2:0]  lvl;
    logic [1:0]  cs;
    logic        alarm;
    logic        notice;
    logic        start_ev;
    logic        stop_ev;
  } reading_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] adc;
    logic        conn;
    logic        chg;
    logic        idle;
  } sample_t;

  typedef struct packed {
    sample_t  s;
    logic     typed;
    reading_t r;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  bgm_in_if  in_ch ();
  bgm_out_if out_ch ();

  battery_gauge_monitor_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [15:0] vtab [8] = '{16'd4142, 16'd3980, 16'd3880, 16'd3803,
                            16'd3752, 16'd3717, 16'd3683, 16'd3610};
  logic [6:0]  ptab [8] = '{7'd100, 7'd86, 7'd72, 7'd58, 7'd43, 7'd29, 7'd15, 7'd1};

  // gauge model state
  logic [15:0] g_mult, g_div, g_volt;
  logic [6:0]  g_pct, g_full_cnt;
  logic        g_notice_sent, g_charging;
  logic [19:0] g_seed_sum;
  logic [3:0]  g_seed_cnt;

  reading_t expected_readings [$];
  int fails = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;

  function automatic logic [15:0] adc_to_mv(input logic [13:0] adc);
    logic [63:0] v;
    if (g_div == 16'd0) return bgm_pkg::MV_MAX;
    v = 64'(adc) * 64'(g_mult) / 64'(g_div);
    return (v > 64'hFFFF) ? bgm_pkg::MV_MAX : v[15:0];
  endfunction

  function logic [1:0] charger_decision(input logic conn, input logic chg, input logic clr);
    if (!conn) begin
      if (clr) g_full_cnt = 7'd0;
      return bgm_pkg::CS_NORMAL;
    end
    if (chg) return (g_full_cnt > 7'd29) ? bgm_pkg::CS_NORMAL : bgm_pkg::CS_CHARGING;
    return (g_full_cnt > 7'd9) ? bgm_pkg::CS_COMPLETE : bgm_pkg::CS_CHARGING;
  endfunction

  function automatic logic [6:0] volt_to_pct(input logic [15:0] v, input logic [1:0] cs);
    int i;
    int stp;
    if (cs == bgm_pkg::CS_COMPLETE) return 7'd100;
    for (i = 0; i < 8; i++) if (v >= vtab[i]) break;
    if (i >= 8) return 7'd0;
    if (i == 0) return 7'd100;
    stp = int'(vtab[i-1] - vtab[i]) / int'(ptab[i-1] - ptab[i]);
    return 7'(int'(v - vtab[i]) / stp + int'(ptab[i]));
  endfunction

  function reading_t gauge_step(input sample_t s);
    reading_t r;
    logic evaluated;
    logic [31:0] nv;
    r = '0;
    evaluated = 1'b0;
    if (s.op == bgm_pkg::OP_SEED) begin
      g_seed_sum = g_seed_sum + 20'(adc_to_mv(s.adc));
      g_seed_cnt = g_seed_cnt + 4'd1;
      if (g_seed_cnt >= SEEDS) begin
        g_volt = 16'(g_seed_sum / SEEDS);
        g_charging = 1'b0;
        r.cs = charger_decision(s.conn, s.chg, 1'b1);
        evaluated = 1'b1;
        g_pct = volt_to_pct(g_volt, r.cs);
        g_seed_sum = '0;
        g_seed_cnt = '0;
      end
    end else if (s.op == bgm_pkg::OP_MEAS && s.idle) begin
      nv = 32'(adc_to_mv(s.adc));
      g_volt = 16'(((nv << 1) + (32'(g_volt) << 3)) / 10);
      r.cs = charger_decision(s.conn, s.chg, 1'b1);
      evaluated = 1'b1;
      g_pct = volt_to_pct(g_volt, r.cs);
      if (g_notice_sent && g_pct > 7'd40) g_notice_sent = 1'b0;
      if (!g_notice_sent && g_pct <= 7'd20) begin
        r.notice = 1'b1;
        g_notice_sent = 1'b1;
      end
      if (!g_charging && g_volt < 16'd3615) r.alarm = 1'b1;
      if (g_volt >= 16'd4100) begin
        if (g_full_cnt < 7'd100) g_full_cnt = g_full_cnt + 7'd1;
      end else begin
        g_full_cnt = 7'd0;
      end
    end else if (s.op == bgm_pkg::OP_POLL) begin
      r.cs = charger_decision(s.conn, s.chg, 1'b1);
      evaluated = 1'b1;
      if (r.cs == bgm_pkg::CS_CHARGING) begin
        if (!g_charging) begin
          g_charging = 1'b1;
          r.start_ev = 1'b1;
        end
      end else if (g_charging) begin
        g_charging = 1'b0;
        r.stop_ev = 1'b1;
      end
    end
    if (!evaluated) r.cs = charger_decision(s.conn, s.chg, 1'b0);
    r.mv = g_volt;
    r.pct = g_pct;
    r.lvl = (g_pct / 20 >= 5) ? 3'd4 : 3'(g_pct / 20);
    return r;
  endfunction

  task automatic send_sample(input sample_t s, input logic typed, input reading_t r);
    reading_t p;
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= s.op;
    in_ch.adc_average <= s.adc;
    in_ch.usb_connected <= s.conn;
    in_ch.charging_pin_low <= s.chg;
    in_ch.monitor_idle <= s.idle;
    do @(posedge clk); while (!in_ch.ready);
    p = gauge_step(s);
    expected_readings.push_back(typed ? r : p);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bgm_pkg::CFG_MULT) g_mult = val;
    else g_div = val;
  endtask

  task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
      fails++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t unexpected beat mv %0d", $time, out_ch.voltage_mv);
          fails++;
        end else begin
          e = expected_readings.pop_front();
          check_field("voltage_mv", e.mv, out_ch.voltage_mv);
          check_field("percent", 16'(e.pct), 16'(out_ch.percent));
          check_field("level", 16'(e.lvl), 16'(out_ch.level));
          check_field("charger_state", 16'(e.cs), 16'(out_ch.charger_state));
          check_field("low_battery_alarm", 16'(e.alarm), 16'(out_ch.low_battery_alarm));
          check_field("twenty_percent_notice", 16'(e.notice),
                      16'(out_ch.twenty_percent_notice));
          check_field("charge_start_event", 16'(e.start_ev), 16'(out_ch.charge_start_event));
          check_field("charge_stop_event", 16'(e.stop_ev), 16'(out_ch.charge_stop_event));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic row_t mk(input logic [1:0] op, input int adc, input logic conn,
                              input logic chg, input logic idle, input logic typed,
                              input int mv, input int pct, input int lvl, input logic [1:0] cs,
                              input logic al, input logic st, input logic sp);
    row_t t;
    t.s = '{op, 14'(adc), conn, chg, idle};
    t.typed = typed;
    t.r = '{16'(mv), 7'(pct), 3'(lvl), cs, al, 1'b0, st, sp};
    return t;
  endfunction

  logic [15:0] mults [7] = '{16'd1, 16'd3, 16'hFFFF, 16'hFFFF, 16'd9, 16'd1, 16'd1};
  logic [15:0] divs  [7] = '{16'd1, 16'd2, 16'd1, 16'hFFFF, 16'd8, 16'hFFFF, 16'd0};
  int counts [7] = '{140, 140, 130, 140, 140, 40, 40};

  initial begin
    row_t rows [$];
    sample_t s;
    int center, tgt, adc;
    logic conn, chg;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bgm_pkg::CFG_MULT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = bgm_pkg::OP_SEED;
    in_ch.adc_average = '0;
    in_ch.usb_connected = 1'b0;
    in_ch.charging_pin_low = 1'b0;
    in_ch.monitor_idle = 1'b0;
    out_ch.ready = 1'b0;
    g_mult = 16'd1; g_div = 16'd1; g_volt = '0; g_pct = '0; g_full_cnt = '0;
    g_notice_sent = 1'b1; g_charging = 1'b0; g_seed_sum = '0; g_seed_cnt = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back(mk(bgm_pkg::OP_POLL, 0, 0, 0, 0, 1, 0, 0, 0,
                      bgm_pkg::CS_NORMAL, 0, 0, 0));
    rows.push_back(mk(OP_NONE, 16383, 1, 1, 1, 1, 0, 0, 0,
                      bgm_pkg::CS_CHARGING, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_MEAS, 16383, 0, 0, 0, 1, 0, 0, 0,
                      bgm_pkg::CS_NORMAL, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_POLL, 0, 1, 1, 0, 1, 0, 0, 0,
                      bgm_pkg::CS_CHARGING, 0, 1, 0));
    rows.push_back(mk(bgm_pkg::OP_POLL, 0, 1, 1, 1, 1, 0, 0, 0,
                      bgm_pkg::CS_CHARGING, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_POLL, 0, 0, 1, 0, 1, 0, 0, 0,
                      bgm_pkg::CS_NORMAL, 0, 0, 1));
    rows.push_back(mk(bgm_pkg::OP_MEAS, 16383, 0, 0, 1, 1, 3276, 0, 0,
                      bgm_pkg::CS_NORMAL, 1, 0, 0));
    for (int k = 0; k < SEEDS - 1; k++)
      rows.push_back(mk(bgm_pkg::OP_SEED, 4142, 0, 0, 0, 0, 0, 0, 0,
                        bgm_pkg::CS_NORMAL, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_SEED, 4142, 0, 0, 0, 1, 4142, 100, 4,
                      bgm_pkg::CS_NORMAL, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_MEAS, 4200, 1, 0, 1, 0, 0, 0, 0,
                      bgm_pkg::CS_NORMAL, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_MEAS, 0, 1, 1, 1, 0, 0, 0, 0,
                      bgm_pkg::CS_NORMAL, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_SEED, 0, 1, 0, 1, 0, 0, 0, 0,
                      bgm_pkg::CS_NORMAL, 0, 0, 0));
    rows.push_back(mk(bgm_pkg::OP_MEAS, 3700, 0, 0, 1, 0, 0, 0, 0,
                      bgm_pkg::CS_NORMAL, 0, 0, 0));
    foreach (rows[i]) send_sample(rows[i].s, rows[i].typed, rows[i].r);
    drain();

    center = 3900;
    conn = 1'b1;
    chg = 1'b1;
    for (int p = 0; p < 7; p++) begin
      write_reg(bgm_pkg::CFG_MULT, mults[p]);
      write_reg(bgm_pkg::CFG_DIV, divs[p]);
      case (p % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 85; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 85; end
        default: begin in_gap_pct = 21; out_stall_pct = 21; end
      endcase
      for (int n = 0; n < counts[p]; n++) begin
        if (n % 40 == 0)
          center = ($urandom_range(7) == 0) ? $urandom_range(5000) : $urandom_range(3550, 4250);
        if (n == counts[p] / 2 && p == 1) drain();
        if ($urandom_range(9) == 0) conn = $urandom_range(1);
        if ($urandom_range(9) == 0) chg = $urandom_range(1);
        tgt = center + $urandom_range(60) - 30;
        if (tgt < 0) tgt = 0;
        if ($urandom_range(3) == 0 || divs[p] == 0 || mults[p] == 0) begin
          adc = $urandom_range(16383);
        end else begin
          adc = int'(longint'(tgt) * divs[p] / mults[p]);
          if (adc > 16383) adc = 16383;
        end
        s.adc = 14'(adc);
        case ($urandom_range(19))
          0, 1, 2: s.op = bgm_pkg::OP_SEED;
          3, 4, 5, 6, 7: s.op = bgm_pkg::OP_POLL;
          8: s.op = OP_NONE;
          default: s.op = bgm_pkg::OP_MEAS;
        endcase
        s.conn = ($urandom_range(9) == 0) ? ~conn : conn;
        s.chg = ($urandom_range(9) == 0) ? ~chg : chg;
        s.idle = ($urandom_range(4) != 0);
        send_sample(s, 1'b0, '0);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
